/* rtl/stl_pkg.sv */
package stl_pkg;

  // Token kinds
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_STRING  = 6'd19;
  localparam logic [5:0] K_NUMBER  = 6'd20;
  localparam logic [5:0] K_IDENT   = 6'd21;
  localparam logic [5:0] K_KEYW0   = 6'd22;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_NONE    = 6'd39;

  // Error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_CHAR    = 2'd1;
  localparam logic [1:0] E_STRING  = 2'd2;
  localparam logic [1:0] E_COMMENT = 2'd3;

  // Characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;
  localparam logic [20:0] POS_SAT  = 21'h0FFFFF;
  localparam int          NKW      = 16;
  localparam int          MAX_RES  = 4;

  typedef enum logic [14:0] {
    M_IDLE     = 15'h0001,
    M_IDENT    = 15'h0002,
    M_NUM      = 15'h0004,
    M_NUMDOT   = 15'h0008,
    M_FRAC     = 15'h0010,
    M_STR      = 15'h0020,
    M_LINECOM  = 15'h0040,
    M_BLOCK    = 15'h0080,
    M_BLKSLASH = 15'h0100,
    M_BLKSTAR  = 15'h0200,
    M_SLASH    = 15'h0400,
    M_BANG     = 15'h0800,
    M_EQ       = 15'h1000,
    M_GT       = 15'h2000,
    M_LT       = 15'h4000
  } mode_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [19:0] start;
    logic [20:0] len;
    logic [15:0] line;
    logic        fin;
  } res_t;

  typedef struct packed {
    logic [2:0]         cnt;
    res_t [MAX_RES-1:0] r;
  } batch_t;

  localparam logic [47:0] KW_VAL [NKW] = '{
    48'("and"), 48'("class"), 48'("else"), 48'("false"),
    48'("fun"), 48'("for"), 48'("if"), 48'("nil"),
    48'("or"), 48'("print"), 48'("return"), 48'("super"),
    48'("this"), 48'("true"), 48'("var"), 48'("while")
  };
  localparam logic [2:0] KW_LEN [NKW] = '{
    3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
    3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [47:0] pfx, input logic [2:0] plen);
    logic [5:0] k;
    k = K_IDENT;
    if (plen >= 3'd1 && plen <= 3'd6) begin
      for (int i = 0; i < NKW; i++) begin
        if (KW_LEN[i] == plen && KW_VAL[i] == pfx) k = K_KEYW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic res_t mk_res(input logic [5:0] kind, input logic [1:0] err,
                                  input logic [19:0] start, input logic [20:0] len,
                                  input logic [15:0] line);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = start;
    r.len   = len;
    r.line  = line;
    r.fin   = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/stl_if.sv */
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       byte_present;
  logic       source_end;
  modport source (output valid, text_byte, byte_present, source_end, input ready);
  modport sink (input valid, text_byte, byte_present, source_end, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_code;
  logic [19:0] token_start;
  logic [20:0] token_length;
  logic [15:0] line_number;
  logic        final_result;
  modport source (output valid, token_kind, error_code, token_start, token_length,
                  line_number, final_result, input ready);
  modport sink (input valid, token_kind, error_code, token_start, token_length,
                line_number, final_result, output ready);
endinterface

/* rtl/script_token_lexer.sv */
// Channel | Dir | Payload                                                   | Item
// src     | in  | text_byte, byte_present, source_end                       | one byte
// tok     | out | token_kind, error_code, token_start, token_length,        | one token
//         |     | line_number, final_result                                 |
// Each accepted byte is lexed in the cycle it is taken; its zero to four tokens
// land in an eight-entry result queue and leave one per cycle while tok is ready.
// Sustained rate is one byte per cycle while the output drains one token per cycle;
// src.ready drops while fewer than four queue slots are free.
// Reset (rst, synchronous) returns the lexer to line one, offset zero, empty queue.
// A stalled tok holds its head token; src keeps flowing until fewer than four slots are free.
module script_token_lexer import stl_pkg::*; #(
  parameter longint unsigned MAX_SOURCE_BYTES = 1048576,
  parameter int unsigned     MAX_COMMENT_NEST = 255
) (
  input  logic       clk,
  input  logic       rst,
  stl_in_if.sink     src,
  stl_out_if.source  tok
);

  logic   room;
  logic   push;
  batch_t batch;

  // Lexer state and per-byte token decision
  stl_core #(
    .MAX_SOURCE_BYTES(MAX_SOURCE_BYTES),
    .MAX_COMMENT_NEST(MAX_COMMENT_NEST)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .src  (src),
    .room (room),
    .push (push),
    .batch(batch)
  );

  // Result queue: absorb a burst of tokens, hand them out one by one
  stl_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .batch(batch),
    .room (room),
    .tok  (tok)
  );

endmodule

/* rtl/stl_core.sv */
module stl_core import stl_pkg::*; #(
  parameter longint unsigned MAX_SOURCE_BYTES = 1048576,
  parameter int unsigned     MAX_COMMENT_NEST = 255
) (
  input  logic   clk,
  input  logic   rst,
  stl_in_if.sink src,
  input  logic   room,
  output logic   push,
  output batch_t batch
);

  localparam logic [20:0] LIMIT = (MAX_SOURCE_BYTES > 64'h100000) ? 21'h100000 :
                                  21'(MAX_SOURCE_BYTES);
  localparam logic [7:0] NEST_LIM = (MAX_COMMENT_NEST > 255) ? 8'd255 :
                                    8'(MAX_COMMENT_NEST);

  mode_t       mode, mode_next;
  logic [7:0]  depth, depth_next;
  logic [15:0] line, line_next;
  logic [20:0] pos, pos_next;
  logic [19:0] lstart, lstart_next;
  logic [47:0] kwp, kwp_next;
  logic [2:0]  plen, plen_next;
  logic        accept;

  assign src.ready = room;
  assign accept    = src.valid && room;
  assign push      = accept;

  always_comb begin
    logic [2:0]  n;
    logic        take, do_idle;
    logic [20:0] p;
    logic [7:0]  c;
    logic [5:0]  base;
    res_t [MAX_RES-1:0] r;
    n = 3'd0;
    r = '0;
    do_idle = 1'b0;
    c = src.text_byte;
    mode_next = mode; depth_next = depth; line_next = line; pos_next = pos;
    lstart_next = lstart; kwp_next = kwp; plen_next = plen;
    take = src.byte_present && pos < LIMIT;
    p = pos;
    base = K_LESS;
    if (take) begin
      unique case (mode)
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (plen < 3'd6) begin
              kwp_next = {kwp[39:0], c};
              plen_next = plen + 3'd1;
            end else begin
              plen_next = 3'd7;
            end
          end else begin
            r[n[1:0]] = mk_res(kw_kind(kwp, plen), E_NONE, lstart, p - {1'b0, lstart}, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_NUM: begin
          if (c == CH_DOT) mode_next = M_NUMDOT;
          else if (!is_digit(c)) begin
            r[n[1:0]] = mk_res(K_NUMBER, E_NONE, lstart, p - {1'b0, lstart}, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) mode_next = M_FRAC;
          else begin
            r[n[1:0]] = mk_res(K_NUMBER, E_NONE, lstart, p - 21'd1 - {1'b0, lstart},
                               line_next);
            n = n + 3'd1;
            r[n[1:0]] = mk_res(K_DOT, E_NONE, 20'(p - 21'd1), 21'd1, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (!is_digit(c)) begin
            r[n[1:0]] = mk_res(K_NUMBER, E_NONE, lstart, p - {1'b0, lstart}, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE) begin
            r[n[1:0]] = mk_res(K_STRING, E_NONE, lstart, p + 21'd1 - {1'b0, lstart},
                               line_next);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else if (c == CH_LF && line_next != LINE_MAX) begin
            line_next = line_next + 16'd1;
          end
        end
        M_LINECOM: begin
          if (c == CH_LF) begin
            if (line_next != LINE_MAX) line_next = line_next + 16'd1;
            mode_next = M_IDLE;
          end
        end
        M_BLOCK, M_BLKSLASH, M_BLKSTAR: begin
          if (mode == M_BLKSLASH && c == CH_STAR) begin
            if (depth < NEST_LIM) depth_next = depth + 8'd1;
            mode_next = M_BLOCK;
          end else if (mode == M_BLKSTAR && c == CH_SLASH) begin
            if (depth != 8'd0) depth_next = depth - 8'd1;
            mode_next = (depth_next == 8'd0) ? M_IDLE : M_BLOCK;
          end else begin
            mode_next = M_BLOCK;
            if (c == CH_SLASH) mode_next = M_BLKSLASH;
            else if (c == CH_STAR) mode_next = M_BLKSTAR;
            else if (c == CH_LF && line_next != LINE_MAX) line_next = line_next + 16'd1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) mode_next = M_LINECOM;
          else if (c == CH_STAR) begin
            depth_next = 8'd1;
            mode_next = M_BLOCK;
          end else begin
            r[n[1:0]] = mk_res(K_SLASH, E_NONE, lstart, 21'd1, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        M_BANG, M_EQ, M_GT, M_LT: begin
          base = (mode == M_BANG) ? K_BANG : (mode == M_EQ) ? K_EQUAL :
                 (mode == M_GT) ? K_GREATER : K_LESS;
          if (c == CH_EQUAL) begin
            r[n[1:0]] = mk_res(base + 6'd1, E_NONE, lstart, 21'd2, line_next);
            n = n + 3'd1;
            mode_next = M_IDLE;
          end else begin
            r[n[1:0]] = mk_res(base, E_NONE, lstart, 21'd1, line_next);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_next = M_IDLE;
        lstart_next = p[19:0];
        unique case (c)
          CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT, CH_MINUS,
          CH_PLUS, CH_SEMI, CH_STAR: begin
            r[n[1:0]] = mk_res(
              (c == CH_LPAREN) ? K_LPAREN : (c == CH_RPAREN) ? K_RPAREN :
              (c == CH_LBRACE) ? K_LBRACE : (c == CH_RBRACE) ? K_RBRACE :
              (c == CH_COMMA) ? K_COMMA : (c == CH_DOT) ? K_DOT :
              (c == CH_MINUS) ? K_MINUS : (c == CH_PLUS) ? K_PLUS :
              (c == CH_SEMI) ? K_SEMI : K_STAR,
              E_NONE, p[19:0], 21'd1, line_next);
            n = n + 3'd1;
          end
          CH_BANG:  mode_next = M_BANG;
          CH_EQUAL: mode_next = M_EQ;
          CH_GT:    mode_next = M_GT;
          CH_LT:    mode_next = M_LT;
          CH_SLASH: mode_next = M_SLASH;
          CH_QUOTE: mode_next = M_STR;
          CH_SPACE, CH_TAB, CH_CR: ;
          CH_LF: if (line_next != LINE_MAX) line_next = line_next + 16'd1;
          default: begin
            if (is_digit(c)) mode_next = M_NUM;
            else if (is_alpha(c)) begin
              mode_next = M_IDENT;
              kwp_next = {40'd0, c};
              plen_next = 3'd1;
            end else begin
              r[n[1:0]] = mk_res(K_NONE, E_CHAR, p[19:0], 21'd1, line_next);
              n = n + 3'd1;
            end
          end
        endcase
      end
      pos_next = pos + 21'd1;
    end

    if (src.source_end) begin
      p = pos_next;
      unique case (mode_next)
        M_IDENT: begin
          r[n[1:0]] = mk_res(kw_kind(kwp_next, plen_next), E_NONE, lstart_next,
                             p - {1'b0, lstart_next}, line_next);
          n = n + 3'd1;
        end
        M_NUM, M_FRAC: begin
          r[n[1:0]] = mk_res(K_NUMBER, E_NONE, lstart_next, p - {1'b0, lstart_next},
                             line_next);
          n = n + 3'd1;
        end
        M_NUMDOT: begin
          r[n[1:0]] = mk_res(K_NUMBER, E_NONE, lstart_next,
                             p - 21'd1 - {1'b0, lstart_next}, line_next);
          n = n + 3'd1;
          r[n[1:0]] = mk_res(K_DOT, E_NONE, 20'(p - 21'd1), 21'd1, line_next);
          n = n + 3'd1;
        end
        M_STR: begin
          r[n[1:0]] = mk_res(K_STRING, E_STRING, lstart_next, p - {1'b0, lstart_next},
                             line_next);
          n = n + 3'd1;
        end
        M_BLOCK, M_BLKSLASH, M_BLKSTAR: begin
          r[n[1:0]] = mk_res(K_NONE, E_COMMENT, lstart_next, p - {1'b0, lstart_next},
                             line_next);
          n = n + 3'd1;
        end
        M_SLASH: begin
          r[n[1:0]] = mk_res(K_SLASH, E_NONE, lstart_next, 21'd1, line_next);
          n = n + 3'd1;
        end
        M_BANG, M_EQ, M_GT, M_LT: begin
          if (n != 3'd4) begin
            r[n[1:0]] = mk_res((mode_next == M_BANG) ? K_BANG : (mode_next == M_EQ) ?
                               K_EQUAL : (mode_next == M_GT) ? K_GREATER : K_LESS,
                               E_NONE, lstart_next, 21'd1, line_next);
            n = n + 3'd1;
          end
        end
        default: ;
      endcase
      // drop the end token when this item already holds four results
      if (n != 3'd4) begin
        r[n[1:0]] = mk_res(K_END, E_NONE, (p > POS_SAT) ? POS_SAT[19:0] : p[19:0],
                           21'd0, line_next);
        n = n + 3'd1;
      end
      mode_next = M_IDLE; depth_next = 8'd0; line_next = 16'd1; pos_next = 21'd0;
      lstart_next = 20'd0; kwp_next = 48'd0; plen_next = 3'd0;
    end
    if (n != 3'd0) r[2'(n - 3'd1)].fin = 1'b1;
    batch.cnt = n;
    batch.r   = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; depth <= 8'd0; line <= 16'd1; pos <= 21'd0;
      lstart <= 20'd0; kwp <= 48'd0; plen <= 3'd0;
    end else if (accept) begin
      mode <= mode_next; depth <= depth_next; line <= line_next; pos <= pos_next;
      lstart <= lstart_next; kwp <= kwp_next; plen <= plen_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && src.source_end |=> mode == M_IDLE && pos == 21'd0 && line == 16'd1)
    else $error("state not cleared after end of source");
  a_pos_limit: assert property (@(posedge clk) disable iff (rst) pos <= LIMIT)
    else $error("byte position past limit");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) batch.cnt <= 3'(MAX_RES))
    else $error("too many tokens for one item");

endmodule

/* rtl/stl_outq.sv */
module stl_outq import stl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  batch_t     batch,
  output logic       room,
  stl_out_if.source  tok
);

  localparam int DEPTH = 8;

  res_t       mem [DEPTH];
  logic [2:0] head, tail;
  logic [3:0] count;
  logic       pop;
  logic [2:0] nadd;
  res_t       hd;

  assign nadd = push ? batch.cnt : 3'd0;
  assign room = count <= 4'(DEPTH - MAX_RES);
  assign pop  = tok.valid && tok.ready;
  assign hd   = mem[head];

  assign tok.valid        = count != 4'd0;
  assign tok.token_kind   = hd.kind;
  assign tok.error_code   = hd.err;
  assign tok.token_start  = hd.start;
  assign tok.token_length = hd.len;
  assign tok.line_number  = hd.line;
  assign tok.final_result = hd.fin;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < nadd) mem[tail + 3'(i)] <= batch.r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 3'd0; tail <= 3'd0; count <= 4'd0;
    end else begin
      tail  <= tail + nadd;
      if (pop) head <= head + 3'd1;
      count <= count + {1'b0, nadd} - {3'd0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 4'(DEPTH))
    else $error("result queue overflow");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && nadd == 3'd0 |=> count == $past(count) - 4'd1)
    else $error("queue count lost a pop");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> 5'(count) + 5'(nadd) <= 5'(DEPTH))
    else $error("push without room");

endmodule
